[design/region_moments_orientation_core_macros.svh]
// Assertion macros used by the controller of the region moments design.
`ifndef REGION_MOMENTS_ORIENTATION_CORE_MACROS_SVH
`define REGION_MOMENTS_ORIENTATION_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RMO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmo: same-cycle check failed");
`define RMO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmo: next-cycle check failed");
`else
`define RMO_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RMO_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/rmo_pkg.sv]
// Shared types, constants and the arctangent table of the region moments design.
`default_nettype none
package rmo_pkg;

  localparam int TARGET_W    = 24;
  localparam int FRAME_DIM_W = 11;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 120;
  localparam int MOM_W       = 64;
  localparam int ANGLE_W     = 35;
  localparam logic [32:0] PI_Q30 = 33'd3373259426;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // Operand selection for the shared divider.
  typedef enum logic [1:0] {
    DIV_ROW    = 2'd0,
    DIV_COL    = 2'd1,
    DIV_ASPECT = 2'd2
  } div_sel_t;

  // Steps of the central moment sequence.
  typedef enum logic [3:0] {
    MOM_CSC = 4'd0,
    MOM_TCN = 4'd1,
    MOM_CCT = 4'd2,
    MOM_RSR = 4'd3,
    MOM_TRN = 4'd4,
    MOM_RRT = 4'd5,
    MOM_RSC = 4'd6,
    MOM_CSR = 4'd7,
    MOM_CRT = 4'd8
  } mom_op_t;

  typedef struct packed {
    logic [TARGET_W-1:0]    target;
    logic [FRAME_DIM_W-1:0] width;
    logic [FRAME_DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    div_sel_t div_sel;
    logic     mom_en;
    mom_op_t  mom_op;
    logic     mom_apply;
    logic     prep;
    logic     cordic_start;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic last_pos;
    logic pipe_busy;
    logic area_zero;
    logic div_done;
    logic cordic_done;
    logic out_free;
  } sts_t;

  // Arctangent of 2^-i in Q.30 radians.
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[design/rmo_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module rmo_divider #(
  parameter int NW = 31,
  parameter int DW = 21
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [NW-1:0] quo,
  output logic               done
);
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   q_r, q_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   den_r, den_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DW:0]     rem_sh;
  logic            ge;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh   = {rem_r, q_r[NW-1]};
    ge       = (rem_sh >= {1'b0, den_r});
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      q_nxt   = {q_r[NW-2:0], ge};
      rem_nxt = ge ? DW'(rem_sh - {1'b0, den_r}) : DW'(rem_sh);
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start && !done_r) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNTW'(NW);
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quo  = q_r;
  assign done = done_r;
endmodule
`default_nettype wire

[design/rmo_cordic.sv]
// Iterative vectoring CORDIC that turns the moment difference into the half angle.
`default_nettype none
module rmo_cordic
  import rmo_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [MOM_W-1:0] x_in,
  input  wire logic signed [MOM_W-1:0] y_in,
  output logic             [15:0]      angle,
  output logic                         done
);
  localparam logic signed [ANGLE_W-1:0] RND = ANGLE_W'(1) <<< (30 - FRAC_BITS);
  localparam int SHIFT = 31 - FRAC_BITS;

  typedef enum logic [5:0] {
    CS_IDLE  = 6'b000001,
    CS_NORM  = 6'b000010,
    CS_ITER  = 6'b000100,
    CS_FLIP  = 6'b001000,
    CS_SIGN  = 6'b010000,
    CS_ROUND = 6'b100000
  } cstate_t;

  cstate_t                    state_r, state_nxt;
  logic signed [MOM_W-1:0]    cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [ANGLE_W-1:0]  z_r, z_nxt;
  logic [4:0]                 i_r, i_nxt;
  logic                       xneg_r, xneg_nxt, yneg_r, yneg_nxt;
  logic [15:0]                angle_r, angle_nxt;
  logic                       done_r, done_nxt;
  logic signed [MOM_W-1:0]    dx, dy;
  logic signed [ANGLE_W-1:0]  step_a, rnd;

  always_comb begin
    dx        = cy_r >>> i_r;
    dy        = cx_r >>> i_r;
    step_a    = $signed(ANGLE_W'(atan_q30(i_r)));
    rnd       = (z_r + RND) >>> SHIFT;
    state_nxt = state_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    z_nxt     = z_r;
    i_nxt     = i_r;
    xneg_nxt  = xneg_r;
    yneg_nxt  = yneg_r;
    angle_nxt = angle_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        if (start && !done_r) begin
          if (x_in == '0 && y_in == '0) begin
            angle_nxt = '0;
            done_nxt  = 1'b1;
          end else begin
            cx_nxt    = x_in[MOM_W-1] ? -x_in : x_in;
            cy_nxt    = y_in[MOM_W-1] ? -y_in : y_in;
            xneg_nxt  = x_in[MOM_W-1];
            yneg_nxt  = y_in[MOM_W-1];
            z_nxt     = '0;
            i_nxt     = '0;
            state_nxt = CS_NORM;
          end
        end
      end
      // Shift both magnitudes until the larger reaches bit 59.
      CS_NORM: begin
        if (cx_r[59] || cy_r[59]) begin
          state_nxt = CS_ITER;
        end else begin
          cx_nxt = cx_r <<< 1;
          cy_nxt = cy_r <<< 1;
        end
      end
      // One micro-rotation per cycle, driving y towards zero.
      CS_ITER: begin
        if (!cy_r[MOM_W-1]) begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          z_nxt  = z_r + step_a;
        end else begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          z_nxt  = z_r - step_a;
        end
        if (i_r == 5'd30) begin
          state_nxt = CS_FLIP;
        end else begin
          i_nxt = i_r + 5'd1;
        end
      end
      CS_FLIP: begin
        if (xneg_r) begin
          z_nxt = $signed(ANGLE_W'(PI_Q30)) - z_r;
        end
        state_nxt = CS_SIGN;
      end
      CS_SIGN: begin
        if (yneg_r) begin
          z_nxt = -z_r;
        end
        state_nxt = CS_ROUND;
      end
      // Halve with round half up into the output format.
      CS_ROUND: begin
        angle_nxt = rnd[15:0];
        done_nxt  = 1'b1;
        state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    z_r     <= z_nxt;
    i_r     <= i_nxt;
    xneg_r  <= xneg_nxt;
    yneg_r  <= yneg_nxt;
    angle_r <= angle_nxt;
    if (!rst_n) begin
      state_r <= CS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign angle = angle_r;
  assign done  = done_r;
endmodule
`default_nettype wire

[design/rmo_datapath.sv]
// Pixel accumulators, end-of-frame arithmetic and the result register.
`default_nettype none
module rmo_datapath
  import rmo_pkg::*;
#(
  parameter int MAX_WIDTH       = 1024,
  parameter int MAX_HEIGHT      = 1024,
  parameter int ANGLE_FRAC_BITS = 14
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  input  wire logic [IN_TDATA_W-1:0]  pixel,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic      [0:0]             out_tuser
);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int KW   = (RW > CW) ? RW : CW;
  localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LSW  = AW + KW;
  localparam int QW   = AW + 2 * KW;
  localparam int RBW  = (RW > 10) ? RW : 10;
  localparam int CBW  = (CW > 10) ? CW : 10;
  localparam int NW   = (LSW > CBW + 9) ? LSW : CBW + 9;
  localparam int DW   = (AW > RBW + 1) ? AW : RBW + 1;
  localparam int DIMW = 14;
  localparam int RLOW_INIT = (MAX_HEIGHT - 1 > 1023) ? MAX_HEIGHT - 1 : 1023;
  localparam int CLOW_INIT = (MAX_WIDTH - 1 > 1023) ? MAX_WIDTH - 1 : 1023;

  // Raster position.
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] hm1;
  logic [CW-1:0] wm1;
  logic          col_last, row_last;

  always_comb begin
    if (cfg.width == '0) begin
      wm1 = '0;
    end else if (DIMW'(cfg.width) > DIMW'(MAX_WIDTH)) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(cfg.width - FRAME_DIM_W'(1));
    end
    if (cfg.height == '0) begin
      hm1 = '0;
    end else if (DIMW'(cfg.height) > DIMW'(MAX_HEIGHT)) begin
      hm1 = RW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(cfg.height - FRAME_DIM_W'(1));
    end
    col_last = (col_r >= wm1);
    row_last = (row_r >= hm1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.accept) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Two stages: colour match, then the squares and cross product.
  logic             s1_v_r, s1_m_r, s2_v_r, s2_m_r;
  logic [RW-1:0]    s1_r_r, s2_r_r;
  logic [CW-1:0]    s1_c_r, s2_c_r;
  logic [2*RW-1:0]  s2_rr_r;
  logic [2*CW-1:0]  s2_cc_r;
  logic [RW+CW-1:0] s2_rc_r;

  always_ff @(posedge clk) begin
    s1_m_r  <= (pixel[TARGET_W-1:0] == cfg.target);
    s1_r_r  <= row_r;
    s1_c_r  <= col_r;
    s2_m_r  <= s1_m_r;
    s2_r_r  <= s1_r_r;
    s2_c_r  <= s1_c_r;
    s2_rr_r <= s1_r_r * s1_r_r;
    s2_cc_r <= s1_c_r * s1_c_r;
    s2_rc_r <= s1_r_r * s1_c_r;
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.accept;
      s2_v_r <= s1_v_r;
    end
  end

  // Raw sums and bounding box, cleared when the result register is loaded.
  logic [AW-1:0]  area_r;
  logic [LSW-1:0] rsum_r, csum_r;
  logic [QW-1:0]  rsq_r, csq_r, cross_r;
  logic [RBW-1:0] rlow_r, rhigh_r;
  logic [CBW-1:0] clow_r, chigh_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      area_r  <= '0;
      rsum_r  <= '0;
      csum_r  <= '0;
      rsq_r   <= '0;
      csq_r   <= '0;
      cross_r <= '0;
      rlow_r  <= RBW'(RLOW_INIT);
      rhigh_r <= '0;
      clow_r  <= CBW'(CLOW_INIT);
      chigh_r <= '0;
    end else if (s2_v_r && s2_m_r) begin
      area_r  <= area_r + AW'(1);
      rsum_r  <= rsum_r + LSW'(s2_r_r);
      csum_r  <= csum_r + LSW'(s2_c_r);
      rsq_r   <= rsq_r + QW'(s2_rr_r);
      csq_r   <= csq_r + QW'(s2_cc_r);
      cross_r <= cross_r + QW'(s2_rc_r);
      if (RBW'(s2_r_r) < rlow_r) rlow_r <= RBW'(s2_r_r);
      if (RBW'(s2_r_r) > rhigh_r) rhigh_r <= RBW'(s2_r_r);
      if (CBW'(s2_c_r) < clow_r) clow_r <= CBW'(s2_c_r);
      if (CBW'(s2_c_r) > chigh_r) chigh_r <= CBW'(s2_c_r);
    end
  end

  // Divider operands and capture of the three quotients.
  logic [CBW:0]   bw;
  logic [RBW:0]   bh;
  logic [NW-1:0]  div_num, quo;
  logic [DW-1:0]  div_den;
  logic           div_done;
  logic [NW-1:0]  rc_r, cc_r, asp_r;

  always_comb begin
    bw = {1'b0, chigh_r} - {1'b0, clow_r} + (CBW + 1)'(1);
    bh = {1'b0, rhigh_r} - {1'b0, rlow_r} + (RBW + 1)'(1);
    unique case (cmd.div_sel)
      DIV_ROW: begin
        div_num = NW'(rsum_r);
        div_den = DW'(area_r);
      end
      DIV_COL: begin
        div_num = NW'(csum_r);
        div_den = DW'(area_r);
      end
      default: begin
        div_num = NW'({bw, 8'h00});
        div_den = DW'(bh);
      end
    endcase
  end

  rmo_divider #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (cmd.div_sel)
        DIV_ROW: rc_r  <= quo;
        DIV_COL: cc_r  <= quo;
        default: asp_r <= quo;
      endcase
    end
  end

  // Central moments from the raw sums, one shared multiplier.
  logic [LSW-1:0]           mul_a, t_r;
  logic [KW-1:0]            mul_b;
  logic [QW-1:0]            prod_r;
  logic signed [MOM_W-1:0]  p_s, mc_r, mr_r, m11_r, x_r, y_r;

  always_comb begin
    p_s = $signed(MOM_W'(prod_r));
    unique case (cmd.mom_op)
      MOM_CSC: begin mul_a = csum_r;        mul_b = cc_r[KW-1:0]; end
      MOM_TCN: begin mul_a = LSW'(area_r);  mul_b = cc_r[KW-1:0]; end
      MOM_CCT: begin mul_a = t_r;           mul_b = cc_r[KW-1:0]; end
      MOM_RSR: begin mul_a = rsum_r;        mul_b = rc_r[KW-1:0]; end
      MOM_TRN: begin mul_a = LSW'(area_r);  mul_b = rc_r[KW-1:0]; end
      MOM_RRT: begin mul_a = t_r;           mul_b = rc_r[KW-1:0]; end
      MOM_RSC: begin mul_a = csum_r;        mul_b = rc_r[KW-1:0]; end
      MOM_CSR: begin mul_a = rsum_r;        mul_b = cc_r[KW-1:0]; end
      default: begin mul_a = t_r;           mul_b = cc_r[KW-1:0]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mom_en && !cmd.mom_apply) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.mom_en && cmd.mom_apply) begin
      unique case (cmd.mom_op)
        MOM_CSC: mc_r  <= $signed(MOM_W'(csq_r)) - (p_s <<< 1);
        MOM_TCN: t_r   <= prod_r[LSW-1:0];
        MOM_CCT: mc_r  <= mc_r + p_s;
        MOM_RSR: mr_r  <= $signed(MOM_W'(rsq_r)) - (p_s <<< 1);
        MOM_TRN: t_r   <= prod_r[LSW-1:0];
        MOM_RRT: mr_r  <= mr_r + p_s;
        MOM_RSC: m11_r <= $signed(MOM_W'(cross_r)) - p_s;
        MOM_CSR: m11_r <= m11_r - p_s;
        default: m11_r <= m11_r + p_s;
      endcase
    end
    if (cmd.prep) begin
      x_r <= mc_r - mr_r;
      y_r <= m11_r <<< 1;
    end
  end

  logic [15:0] angle;
  logic        cordic_done;

  rmo_cordic #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cordic_start),
    .x_in  (x_r),
    .y_in  (y_r),
    .angle (angle),
    .done  (cordic_done)
  );

  // Result register; it holds until the transfer completes.
  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_d_r;
  logic                   out_e_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_e_r <= (area_r == '0);
      if (area_r == '0) begin
        out_d_r <= '0;
      end else begin
        out_d_r <= {4'h0, asp_r[18:0], chigh_r[9:0], clow_r[9:0], rhigh_r[9:0],
                    rlow_r[9:0], angle, cc_r[9:0], rc_r[9:0], 21'(area_r)};
      end
    end
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_d_r;
  assign out_tuser[0] = out_e_r;

  assign sts.last_pos    = col_last && row_last;
  assign sts.pipe_busy   = s1_v_r || s2_v_r;
  assign sts.area_zero   = (area_r == '0);
  assign sts.div_done    = div_done;
  assign sts.cordic_done = cordic_done;
  assign sts.out_free    = !out_v_r || out_tready;
endmodule
`default_nettype wire

[design/rmo_ctrl.sv]
// Frame controller that sequences accumulation and the end-of-frame arithmetic.
`default_nettype none
`include "region_moments_orientation_core_macros.svh"
module rmo_ctrl
  import rmo_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  localparam logic [4:0] MOM_LAST = 5'd17;

  typedef enum logic [8:0] {
    ST_ACCUM  = 9'b000000001,
    ST_DRAIN  = 9'b000000010,
    ST_DIV_R  = 9'b000000100,
    ST_DIV_C  = 9'b000001000,
    ST_DIV_A  = 9'b000010000,
    ST_MOM    = 9'b000100000,
    ST_PREP   = 9'b001000000,
    ST_ORIENT = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] step_r, step_nxt;

  // Next state and the commands of each state.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_tready = (state_r == ST_ACCUM);
    unique case (state_r)
      ST_ACCUM: begin
        cmd.accept = in_tvalid;
        if (in_tvalid && sts.last_pos) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = sts.area_zero ? ST_EMIT : ST_DIV_R;
      end
      ST_DIV_R: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ROW;
        if (sts.div_done) state_nxt = ST_DIV_C;
      end
      ST_DIV_C: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_COL;
        if (sts.div_done) state_nxt = ST_DIV_A;
      end
      ST_DIV_A: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ASPECT;
        if (sts.div_done) state_nxt = ST_MOM;
      end
      // Each moment step multiplies into the product register, then accumulates in the next cycle.
      ST_MOM: begin
        cmd.mom_en    = 1'b1;
        cmd.mom_op    = mom_op_t'(step_r[4:1]);
        cmd.mom_apply = step_r[0];
        if (step_r == MOM_LAST) begin
          step_nxt  = '0;
          state_nxt = ST_PREP;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_ORIENT;
      end
      ST_ORIENT: begin
        cmd.cordic_start = 1'b1;
        if (sts.cordic_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_ACCUM;
        end
      end
      default: state_nxt = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // The result is loaded only once the pixel stages have drained.
  `RMO_ASSERT_IMP(a_load_drained, clk, rst_n, cmd.load_out, !sts.pipe_busy)
  // The transfer of a frame's last pixel stops further input.
  `RMO_ASSERT_NXT(a_frame_end_stall, clk, rst_n, cmd.accept && sts.last_pos, !in_tready)
  // Quotients come back only while a division is being waited for.
  `RMO_ASSERT_IMP(a_div_done_state, clk, rst_n, sts.div_done, (state_r == ST_DIV_R) || (state_r == ST_DIV_C) || (state_r == ST_DIV_A))
endmodule
`default_nettype wire

[design/region_moments_orientation_core.sv]
// Top level: configuration registers, controller and datapath of the region moments core.
// Pixels are taken one per cycle through a frame while in_tvalid is high; after the last pixel
// in_tready stays low while the core drains the pixel stages, runs three divisions, the
// central moment steps, a set-up step, the CORDIC normalisation, micro-rotations, quadrant
// and sign fixes and rounding, and loads the result (an empty region skips straight from
// draining to the load). Reset is synchronous and active low; it clears counters and valid.
`default_nettype none
module region_moments_orientation_core
  import rmo_pkg::*;
#(
  parameter int MAX_WIDTH       = 1024,
  parameter int MAX_HEIGHT      = 1024,
  parameter int ANGLE_FRAC_BITS = 14
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // pixel_color [23:0]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // object_area [20:0], centroid_row [30:21], centroid_col [40:31], orientation [56:41],
  // row_min [66:57], row_max [76:67], col_min [86:77], col_max [96:87],
  // box_ratio [115:97], zeros [119:116]
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  // region_empty [0]
  output logic      [0:0]             out_tuser,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;

  // Register writes at the access phase of an APB transfer.
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= '0;
      cfg_r.width  <= FRAME_DIM_W'(1024);
      cfg_r.height <= FRAME_DIM_W'(1024);
    end else if (wr_en) begin
      if (cfg_paddr[3:2] == REG_TARGET) cfg_r.target <= cfg_pwdata[TARGET_W-1:0];
      if (cfg_paddr[3:2] == REG_WIDTH)  cfg_r.width  <= cfg_pwdata[FRAME_DIM_W-1:0];
      if (cfg_paddr[3:2] == REG_HEIGHT) cfg_r.height <= cfg_pwdata[FRAME_DIM_W-1:0];
    end
  end

  // Read-back of the register addressed.
  always_comb begin
    priority if (cfg_paddr[3:2] == REG_TARGET) begin
      cfg_prdata = CFG_DATA_W'(cfg_r.target);
    end else if (cfg_paddr[3:2] == REG_WIDTH) begin
      cfg_prdata = CFG_DATA_W'(cfg_r.width);
    end else if (cfg_paddr[3:2] == REG_HEIGHT) begin
      cfg_prdata = CFG_DATA_W'(cfg_r.height);
    end else begin
      cfg_prdata = '0;
    end
  end

  assign cfg_pready = 1'b1;

  rmo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rmo_datapath #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .sts        (sts),
    .pixel      (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );
endmodule
`default_nettype wire
